@@ hw/rtl/sqmr_pkg.sv @@
package sqmr_pkg;

	localparam int MAX_OBJECTS_DEF = 16;

	localparam int POS_W   = 10;
	localparam int PRIO_W  = 8;
	localparam int ENTRY_W = 2 * POS_W + PRIO_W;
	localparam int CALC_W  = POS_W + 2;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_MOVE   = 2'd1;
	localparam logic [1:0] OP_RENDER = 2'd2;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INTENSITY = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SALIENCY  = 3'd6;

	localparam logic [5:0]       RADIUS_RST = 6'd2;
	localparam logic [POS_W-1:0] WIDTH_RST  = 10'd64;
	localparam logic [POS_W-1:0] HEIGHT_RST = 10'd64;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [3:0]        obj_index;
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
		logic [PRIO_W-1:0] prio_in;
		logic              axis_bit;
		logic              direction_bit;
	} sqmr_in_t;

	typedef struct packed {
		logic [POS_W-1:0]   out_x;
		logic [POS_W-1:0]   out_y;
		logic               covered;
		logic [PRIO_W-1:0]  top_priority;
		logic signed [15:0] intensity;
		logic signed [15:0] saliency;
	} sqmr_out_t;

	typedef struct packed {
		logic [5:0]         radius;
		logic [POS_W-1:0]   image_width;
		logic [POS_W-1:0]   image_height;
		logic               move_mode;
		logic [4:0]         object_count;
		logic signed [15:0] intensity;
		logic signed [15:0] saliency;
	} sqmr_cfg_t;

	function automatic logic [CALC_W-1:0] absd(input logic signed [CALC_W-1:0] a,
		input logic signed [CALC_W-1:0] b);
		absd = (a > b) ? CALC_W'(a - b) : CALC_W'(b - a);
	endfunction

endpackage

@@ hw/rtl/sqmr_chan_if.sv @@
interface sqmr_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/sqmr_ram.sv @@
module sqmr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/sqmr_cfg.sv @@
module sqmr_cfg import sqmr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 we,
	input  logic [CFG_IDX_W-1:0] idx,
	input  logic [CFG_W-1:0]     wdata,
	output sqmr_cfg_t            cfg
);

	sqmr_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radius       <= RADIUS_RST;
			cfg_q.image_width  <= WIDTH_RST;
			cfg_q.image_height <= HEIGHT_RST;
			cfg_q.move_mode    <= 1'b0;
			cfg_q.object_count <= '0;
			cfg_q.intensity    <= '0;
			cfg_q.saliency     <= '0;
		end else if (we) begin
			case (idx)
				REG_RADIUS:    cfg_q.radius       <= wdata[5:0];
				REG_WIDTH:     cfg_q.image_width  <= wdata[POS_W-1:0];
				REG_HEIGHT:    cfg_q.image_height <= wdata[POS_W-1:0];
				REG_MODE:      cfg_q.move_mode    <= wdata[0];
				REG_COUNT:     cfg_q.object_count <= wdata[4:0];
				REG_INTENSITY: cfg_q.intensity    <= $signed(wdata);
				REG_SALIENCY:  cfg_q.saliency     <= $signed(wdata);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hw/rtl/square_object_move_and_render_unit.sv @@
// channel | dir | payload      | accepted when
// cmd     | in  | sqmr_in_t    | cmd.valid && cmd.ready
// res     | out | sqmr_out_t   | res.valid && res.ready
// cfg     | in  | index, data  | cfg_we high
//
// Load, spare opcode and move beyond the table go straight to the result. Render scans every entry in use;
// a move of an entry in use reads that entry, then scans every entry in use; other moves only read the entry.
// The scan runs through the one read port of the table RAM, one entry per cycle.
// One item is worked on at a time.
// Reset clears control and configuration; table contents are undefined until loaded.
// cmd is taken while the previous result still waits in the output register.
module square_object_move_and_render_unit import sqmr_pkg::*; #(
	parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	sqmr_chan_if.sink            cmd,
	sqmr_chan_if.source          res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
	localparam int CW = $clog2(MAX_OBJECTS + 1);
	localparam int EW = (CW > 5) ? CW : 5;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SELF = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	localparam logic signed [CALC_W-1:0] STEP = CALC_W'(1);

	sqmr_cfg_t cfg;

	sqmr_cfg u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (cfg_we),
		.idx   (cfg_index),
		.wdata (cfg_wdata),
		.cfg   (cfg)
	);

	logic [1:0] state_q;
	logic [CW-1:0] cnt_q, lim_q, used;
	logic [EW-1:0] count_ext;
	logic rd_v_s1, rd_self_s1;
	logic [AW-1:0] rd_j_s1;
	logic res_v_q;
	sqmr_out_t res_q;

	sqmr_in_t item_q;
	logic valid_idx_q, in_use_q;
	logic [POS_W-1:0] cur_x_q, cur_y_q;
	logic [PRIO_W-1:0] cur_p_q, best_q;
	logic close_lo_q, close_hi_q;

	logic issue;
	logic [AW-1:0] raddr, idx_addr;
	logic [ENTRY_W-1:0] rdata, wdata;
	logic we;
	logic [POS_W-1:0] rx, ry;
	logic [PRIO_W-1:0] rp;
	logic accept, fin_go;
	logic in_use_now, valid_idx_now;

	assign count_ext = EW'(cfg.object_count);
	assign used = (count_ext > EW'(MAX_OBJECTS)) ? CW'(MAX_OBJECTS) : CW'(count_ext);
	assign idx_addr = AW'(item_q.obj_index);
	assign valid_idx_now = (cmd.data.obj_index < MAX_OBJECTS);
	assign in_use_now = (cmd.data.obj_index < used);

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept = cmd.valid && cmd.ready;
	assign fin_go = (state_q == ST_FIN) && (!res_v_q || res.ready);

	assign issue = (state_q == ST_SELF) || ((state_q == ST_SCAN) && (cnt_q < lim_q));
	assign raddr = (state_q == ST_SELF) ? idx_addr : cnt_q[AW-1:0];
	assign {rx, ry, rp} = rdata;

	sqmr_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_OBJECTS)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(idx_addr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// candidate positions one step down and up along the chosen axis
	logic signed [CALC_W-1:0] cx, cy, lo_x, lo_y, hi_x, hi_y, jx, jy;
	logic signed [CALC_W-1:0] span, r12, lo_pos, hi_pos, hi_lim;
	logic near_lo, near_hi, cover_hit, other;

	always_comb begin
		cx = $signed({2'b00, cur_x_q});
		cy = $signed({2'b00, cur_y_q});
		jx = $signed({2'b00, rx});
		jy = $signed({2'b00, ry});
		r12 = $signed(CALC_W'(cfg.radius));
		span = $signed({5'b00000, cfg.radius, 1'b1});
		lo_x = item_q.axis_bit ? cx - STEP : cx;
		hi_x = item_q.axis_bit ? cx + STEP : cx;
		lo_y = item_q.axis_bit ? cy : cy - STEP;
		hi_y = item_q.axis_bit ? cy : cy + STEP;
		other = (rd_j_s1 != idx_addr);
		near_lo = other && (absd(lo_x, jx) <= span) && (absd(lo_y, jy) <= span);
		near_hi = other && (absd(hi_x, jx) <= span) && (absd(hi_y, jy) <= span);
		cover_hit = (absd(jx, $signed({2'b00, item_q.pos_x})) <= r12)
			&& (absd(jy, $signed({2'b00, item_q.pos_y})) <= r12)
			&& (rp > best_q);
		lo_pos = item_q.axis_bit ? cx - STEP : cy - STEP;
		hi_pos = item_q.axis_bit ? cx + STEP : cy + STEP;
		hi_lim = item_q.axis_bit ? $signed({2'b00, cfg.image_width}) - r12
			: $signed({2'b00, cfg.image_height}) - r12;
	end

	logic lo_ok, hi_ok;
	logic [POS_W-1:0] nx, ny;
	sqmr_out_t res_d;

	always_comb begin
		lo_ok = !(lo_pos <= r12) && (cfg.move_mode || !close_lo_q);
		hi_ok = !(hi_pos >= hi_lim) && (cfg.move_mode || !close_hi_q);
		nx = cur_x_q;
		ny = cur_y_q;
		if (lo_ok && (!hi_ok || item_q.direction_bit)) begin
			nx = lo_x[POS_W-1:0];
			ny = lo_y[POS_W-1:0];
		end else if (hi_ok) begin
			nx = hi_x[POS_W-1:0];
			ny = hi_y[POS_W-1:0];
		end
		res_d = '0;
		we = 1'b0;
		wdata = {item_q.pos_x, item_q.pos_y, item_q.prio_in};
		case (item_q.opcode)
			OP_LOAD: begin
				if (valid_idx_q) begin
					we = fin_go;
					res_d.out_x = item_q.pos_x;
					res_d.out_y = item_q.pos_y;
				end
			end
			OP_MOVE: begin
				if (valid_idx_q) begin
					if (in_use_q) begin
						we = fin_go;
						wdata = {nx, ny, cur_p_q};
						res_d.out_x = nx;
						res_d.out_y = ny;
					end else begin
						res_d.out_x = cur_x_q;
						res_d.out_y = cur_y_q;
					end
				end
			end
			OP_RENDER: begin
				if (best_q != '0) begin
					res_d.covered = 1'b1;
					res_d.top_priority = best_q;
					res_d.intensity = cfg.intensity;
					res_d.saliency = cfg.saliency;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			lim_q <= '0;
			rd_v_s1 <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			if (issue && (state_q == ST_SCAN)) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (fin_go) begin
				res_v_q <= 1'b1;
			end else if (res.ready) begin
				res_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						case (cmd.data.opcode)
							OP_MOVE: begin
								lim_q <= in_use_now ? used : '0;
								state_q <= valid_idx_now ? ST_SELF : ST_FIN;
							end
							OP_RENDER: begin
								lim_q <= used;
								state_q <= ST_SCAN;
							end
							default: begin
								lim_q <= used;
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_SELF: state_q <= ST_SCAN;
				ST_SCAN: begin
					if (!issue && !rd_v_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_self_s1 <= (state_q == ST_SELF);
		rd_j_s1 <= raddr;
		if (accept) begin
			item_q <= cmd.data;
			valid_idx_q <= valid_idx_now;
			in_use_q <= in_use_now;
			close_lo_q <= 1'b0;
			close_hi_q <= 1'b0;
			best_q <= '0;
		end
		if (rd_v_s1) begin
			if (rd_self_s1) begin
				cur_x_q <= rx;
				cur_y_q <= ry;
				cur_p_q <= rp;
			end else if (item_q.opcode == OP_RENDER) begin
				if (cover_hit) begin
					best_q <= rp;
				end
			end else begin
				close_lo_q <= close_lo_q | near_lo;
				close_hi_q <= close_hi_q | near_hi;
			end
		end
		if (fin_go) begin
			res_q <= res_d;
		end
	end

	assign res.valid = res_v_q;
	assign res.data = res_q;

endmodule

@@ dv/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import sqmr_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int N_REGS = 7;
	localparam int ITEM_GOAL = 1850;
	localparam int CALM_FROM = 1650;
	localparam int STUCK_LIMIT = 2000;

	class object_table_sb;
		logic [5:0]        radius;
		logic [POS_W-1:0]  img_w;
		logic [POS_W-1:0]  img_h;
		logic              mode;
		logic [4:0]        count;
		logic [15:0]       inten;
		logic [15:0]       sal;
		logic [POS_W-1:0]  cx[MAX_OBJECTS_DEF];
		logic [POS_W-1:0]  cy[MAX_OBJECTS_DEF];
		logic [PRIO_W-1:0] prio[MAX_OBJECTS_DEF];
		sqmr_out_t         expected_results[$];
		int                errors;
		int                checked;
		int                moves;
		int                renders;
		int                covered_hits;

		function new();
			radius = RADIUS_RST;
			img_w = WIDTH_RST;
			img_h = HEIGHT_RST;
			mode = 1'b0;
			count = '0;
			inten = '0;
			sal = '0;
			foreach (cx[i]) begin
				cx[i] = '0;
				cy[i] = '0;
				prio[i] = '0;
			end
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_RADIUS: radius = val[5:0];
				REG_WIDTH: img_w = val[POS_W-1:0];
				REG_HEIGHT: img_h = val[POS_W-1:0];
				REG_MODE: mode = val[0];
				REG_COUNT: count = val[4:0];
				REG_INTENSITY: inten = val;
				REG_SALIENCY: sal = val;
				default: ;
			endcase
		endfunction

		function int used_entries();
			return (count > MAX_OBJECTS_DEF) ? MAX_OBJECTS_DEF : int'(count);
		endfunction

		function int gap(int a, int b);
			return (a > b) ? a - b : b - a;
		endfunction

		function bit crowded(int k, int x, int y);
			int span;
			span = 2 * int'(radius) + 1;
			for (int j = 0; j < used_entries(); j++)
				if (j != k && gap(x, cx[j]) <= span && gap(y, cy[j]) <= span)
					return 1'b1;
			return 1'b0;
		endfunction

		function bit step_free(int k, int x, int y, bit blocked);
			if (blocked)
				return 1'b0;
			if (!mode && crowded(k, x, y))
				return 1'b0;
			return 1'b1;
		endfunction

		function void note_command(sqmr_in_t c);
			sqmr_out_t e;
			int        k;
			int        x;
			int        y;
			int        r;
			int        best;
			bit        lo;
			bit        hi;
			e = '0;
			r = radius;
			k = c.obj_index;
			case (c.opcode)
				OP_LOAD: begin
					cx[k] = c.pos_x;
					cy[k] = c.pos_y;
					prio[k] = c.prio_in;
					e.out_x = c.pos_x;
					e.out_y = c.pos_y;
				end
				OP_MOVE: begin
					x = cx[k];
					y = cy[k];
					if (k < used_entries()) begin
						if (c.axis_bit) begin
							lo = step_free(k, x - 1, y, x - 1 <= r);
							hi = step_free(k, x + 1, y, x + 1 >= int'(img_w) - r);
							if (lo && (!hi || c.direction_bit))
								x = x - 1;
							else if (hi)
								x = x + 1;
						end else begin
							lo = step_free(k, x, y - 1, y - 1 <= r);
							hi = step_free(k, x, y + 1, y + 1 >= int'(img_h) - r);
							if (lo && (!hi || c.direction_bit))
								y = y - 1;
							else if (hi)
								y = y + 1;
						end
						cx[k] = POS_W'(x);
						cy[k] = POS_W'(y);
					end
					e.out_x = cx[k];
					e.out_y = cy[k];
					moves++;
				end
				OP_RENDER: begin
					best = 0;
					for (int j = 0; j < used_entries(); j++)
						if (gap(cx[j], c.pos_x) <= r && gap(cy[j], c.pos_y) <= r &&
								prio[j] > best)
							best = prio[j];
					if (best > 0) begin
						e.covered = 1'b1;
						e.top_priority = PRIO_W'(best);
						e.intensity = inten;
						e.saliency = sal;
						covered_hits++;
					end
					renders++;
				end
				default: ;
			endcase
			expected_results.push_back(e);
		endfunction

		function void check_field(string name, logic signed [31:0] want,
				logic signed [31:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(sqmr_out_t got);
			sqmr_out_t want;
			if (expected_results.size() == 0) begin
				$error("result item arrived with nothing outstanding");
				errors++;
				return;
			end
			want = expected_results.pop_front();
			checked++;
			check_field("out_x", want.out_x, got.out_x);
			check_field("out_y", want.out_y, got.out_y);
			check_field("covered", want.covered, got.covered);
			check_field("top_priority", want.top_priority, got.top_priority);
			check_field("intensity", want.intensity, got.intensity);
			check_field("saliency", want.saliency, got.saliency);
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	sqmr_chan_if #(.T(sqmr_in_t))  cmd_ch ();
	sqmr_chan_if #(.T(sqmr_out_t)) res_ch ();

	square_object_move_and_render_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	object_table_sb table_sb = new();

	int cur[N_REGS];
	int sent;
	int phases;
	int stuck_cycles;
	bit calm;
	bit clustered;
	int cl_x;
	int cl_y;
	int cl_win;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		if (arst_n && cmd_ch.valid && cmd_ch.ready)
			table_sb.note_command(cmd_ch.data);
		if (arst_n && res_ch.valid && res_ch.ready)
			table_sb.check_result(res_ch.data);
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (cmd_ch.valid && cmd_ch.ready) ||
				(res_ch.valid && res_ch.ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", stuck_cycles);
			$display("square_object_move_and_render_unit regression: fail");
			$finish;
		end
	end

	// result side back-pressure
	initial begin
		res_ch.ready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	end

	function automatic int place(int centre, int spread);
		int v;
		v = centre + int'($urandom_range(0, 2 * spread)) - spread;
		return (v < 0) ? 0 : (v > 1023) ? 1023 : v;
	endfunction

	task automatic send_item(logic [1:0] op, int idx, int x, int y, int p, int axis,
			int dir);
		sqmr_in_t it;
		it.opcode = op;
		it.obj_index = 4'(idx);
		it.pos_x = POS_W'(x);
		it.pos_y = POS_W'(y);
		it.prio_in = PRIO_W'(p);
		it.axis_bit = axis[0];
		it.direction_bit = dir[0];
		if (!calm && $urandom_range(0, 5) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= it;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		sent++;
		calm = (sent >= CALM_FROM);
	endtask

	task automatic settle();
		cmd_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (table_sb.expected_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_settings();
		for (int i = 0; i < N_REGS; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_wdata <= CFG_W'(cur[i]);
			table_sb.write_reg(CFG_IDX_W'(i), CFG_W'(cur[i]));
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
		phases++;
	endtask

	task automatic load_entry(int i);
		int x;
		int y;
		int p;
		if ($urandom_range(0, 9) == 0) begin
			x = $urandom_range(0, 1023);
			y = $urandom_range(0, 1023);
		end else if (clustered) begin
			x = place(cl_x, cl_win);
			y = place(cl_y, cl_win);
		end else begin
			x = $urandom_range(0, cur[REG_WIDTH] - 1);
			y = $urandom_range(0, cur[REG_HEIGHT] - 1);
		end
		case ($urandom_range(0, 9))
			0: p = 0;
			1: p = 255;
			default: p = $urandom_range(1, 255);
		endcase
		send_item(OP_LOAD, i, x, y, p, $urandom_range(0, 1), $urandom_range(0, 1));
	endtask

	task automatic random_phase(int n_ops);
		int n;
		int j;
		int r;
		int kind;
		case ($urandom_range(0, 9))
			0: cur[REG_RADIUS] = 0;
			1: cur[REG_RADIUS] = 63;
			2: cur[REG_RADIUS] = $urandom_range(0, 63);
			default: cur[REG_RADIUS] = $urandom_range(1, 5);
		endcase
		for (int d = 0; d < 2; d++) begin
			case ($urandom_range(0, 9))
				0: cur[REG_WIDTH + d] = 1;
				1: cur[REG_WIDTH + d] = 1023;
				2: cur[REG_WIDTH + d] = $urandom_range(1, 1023);
				default: cur[REG_WIDTH + d] = $urandom_range(16, 200);
			endcase
		end
		cur[REG_MODE] = $urandom_range(0, 1);
		case ($urandom_range(0, 9))
			0: cur[REG_COUNT] = 0;
			1: cur[REG_COUNT] = 16;
			2: cur[REG_COUNT] = $urandom_range(17, 31);
			default: cur[REG_COUNT] = $urandom_range(1, 16);
		endcase
		for (int d = 0; d < 2; d++) begin
			case ($urandom_range(0, 5))
				0: cur[REG_INTENSITY + d] = 'h7FFF;
				1: cur[REG_INTENSITY + d] = 'h8000;
				default: cur[REG_INTENSITY + d] = $urandom_range(0, 'hFFFF);
			endcase
		end
		apply_settings();

		r = cur[REG_RADIUS];
		n = table_sb.used_entries();
		clustered = $urandom_range(0, 1);
		cl_win = 6 * r + 10;
		cl_x = $urandom_range(0, cur[REG_WIDTH] - 1);
		cl_y = $urandom_range(0, cur[REG_HEIGHT] - 1);
		for (int i = 0; i < MAX_OBJECTS_DEF; i++)
			load_entry(i);

		for (int i = 0; i < n_ops; i++) begin
			kind = $urandom_range(0, 99);
			if (n == 0 || $urandom_range(0, 4) == 0)
				j = $urandom_range(0, MAX_OBJECTS_DEF - 1);
			else
				j = $urandom_range(0, n - 1);
			if (kind < 50)
				send_item(OP_MOVE, j, $urandom_range(0, 1023), $urandom_range(0, 1023),
					$urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 1));
			else if (kind < 88) begin
				if ($urandom_range(0, 6) == 0)
					send_item(OP_RENDER, $urandom_range(0, 15), $urandom_range(0, 1023),
						$urandom_range(0, 1023), $urandom_range(0, 255), $urandom_range(0, 1),
						$urandom_range(0, 1));
				else
					send_item(OP_RENDER, $urandom_range(0, 15),
						place(table_sb.cx[j], r + 1), place(table_sb.cy[j], r + 1),
						$urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 1));
			end else if (kind < 95)
				load_entry($urandom_range(0, MAX_OBJECTS_DEF - 1));
			else
				send_item(OP_SPARE, $urandom_range(0, 15), $urandom_range(0, 1023),
					$urandom_range(0, 1023), $urandom_range(0, 255), $urandom_range(0, 1),
					$urandom_range(0, 1));
		end
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		cur = '{2, 64, 64, 0, 0, 0, 0};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: fill the whole table first, extremes included
		send_item(OP_LOAD, 0, 0, 0, 0, 0, 0);
		send_item(OP_LOAD, 1, 1023, 1023, 255, 1, 1);
		send_item(OP_LOAD, 2, 20, 20, 7, 0, 0);
		send_item(OP_LOAD, 3, 20, 20, 7, 0, 0);
		send_item(OP_LOAD, 4, 40, 30, 100, 0, 0);
		send_item(OP_LOAD, 5, 45, 30, 90, 0, 0);
		for (int i = 6; i < MAX_OBJECTS_DEF; i++)
			send_item(OP_LOAD, i, $urandom_range(3, 60), $urandom_range(3, 60),
				$urandom_range(1, 254), 0, 0);
		send_item(OP_SPARE, 9, 512, 300, 77, 1, 0);
		settle();

		cur[REG_COUNT] = 16;
		cur[REG_INTENSITY] = 'h7FFF;
		cur[REG_SALIENCY] = 'h8000;
		apply_settings();
		send_item(OP_RENDER, 0, 0, 0, 0, 0, 0);
		send_item(OP_RENDER, 0, 1023, 1023, 0, 0, 0);
		send_item(OP_RENDER, 0, 21, 19, 0, 0, 0);
		send_item(OP_RENDER, 0, 44, 31, 0, 0, 0);
		send_item(OP_MOVE, 1, 0, 0, 0, 1, 0);
		send_item(OP_MOVE, 0, 0, 0, 0, 0, 1);
		send_item(OP_MOVE, 4, 0, 0, 0, 1, 0);
		send_item(OP_MOVE, 2, 0, 0, 0, 0, 1);
		settle();

		// entry outside the used range
		cur[REG_COUNT] = 3;
		cur[REG_MODE] = 1;
		apply_settings();
		send_item(OP_MOVE, 10, 0, 0, 0, 1, 1);
		settle();

		// count beyond the table size
		cur[REG_COUNT] = 31;
		apply_settings();
		send_item(OP_RENDER, 0, 45, 30, 0, 0, 0);
		settle();

		while (sent < ITEM_GOAL)
			random_phase($urandom_range(30, 60));

		settle();
		repeat (24) @(posedge clk);
		if (table_sb.expected_results.size() != 0) begin
			$error("%0d results never arrived", table_sb.expected_results.size());
			table_sb.errors++;
		end
		$display("%0d items sent over %0d register settings, %0d results checked",
			sent, phases, table_sb.checked);
		$display("%0d moves, %0d renders (%0d covered), %0d errors", table_sb.moves,
			table_sb.renders, table_sb.covered_hits, table_sb.errors);
		if (table_sb.errors == 0)
			$display("square_object_move_and_render_unit regression: pass");
		else
			$display("square_object_move_and_render_unit regression: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/sqmr_pkg.sv
hw/rtl/sqmr_chan_if.sv
hw/rtl/sqmr_ram.sv
hw/rtl/sqmr_cfg.sv
hw/rtl/square_object_move_and_render_unit.sv
dv/testbench.sv
